/* hw/rtl/rws_pkg.sv */
// rws_pkg: request, response and queue item types for the roulette wheel selector.
// No dependencies; imported by rws_front, rws_back and roulette_wheel_selector.
`default_nettype none

package rws_pkg;

  localparam int FIT_W    = 32;
  localparam int SUM_BITS = 41;
  localparam int IDX_BITS = 9;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_kind_t;

  typedef struct packed {
    logic                cmd;
    logic                new_population;
    logic [FIT_W-1:0]    fitness;
    logic [SUM_BITS-1:0] pick_value;
  } req_t;

  typedef struct packed {
    logic [IDX_BITS-1:0] selected_index;
    logic [SUM_BITS-1:0] total_sum;
    logic                empty_res;
  } rsp_t;

  typedef struct packed {
    op_kind_t            op;
    logic                restart;
    logic [FIT_W-1:0]    fitness;
    logic [SUM_BITS-1:0] pick_value;
  } item_t;

endpackage

`default_nettype wire

/* hw/rtl/roulette_wheel_selector.sv */
// roulette_wheel_selector: fitness-proportionate selection over a prefix-sum table.
// Loads and queries are taken from the queue only while the back end is idle; a query
// answers after its binary search, one table read per binary-search probe.
// Throughput: one load per cycle while idle; a query holds the back end until it answers.
// Reset (synchronous): clears entry count, running total, queue and result valid;
// the table itself is not cleared, and results depend only on entries below the entry count.
`default_nettype none

module roulette_wheel_selector import rws_pkg::*; #(
  parameter int POP_SIZE     = 512,
  parameter int FITNESS_BITS = 32
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_stall,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_stall,
  output rsp_t      rsp
);

  logic  q_valid;
  logic  q_take;
  item_t q_item;

  rws_front #(
    .FITNESS_BITS(FITNESS_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_take   (q_take)
  );

  rws_back #(
    .POP_SIZE(POP_SIZE)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_take   (q_take),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  a_empty_result_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.empty_res |-> (rsp.selected_index == '0) && (rsp.total_sum == '0))
    else $error("empty result carries nonzero index or total");

  a_reset_clears_result: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result valid after reset");

  a_request_reaches_back: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall && !q_valid |=> q_valid)
    else $error("accepted request not presented to back end");

endmodule

`default_nettype wire

/* hw/rtl/rws_front.sv */
// rws_front: accepts requests, decodes them into queue items and buffers them
// in a two-entry queue toward the back end. Depends on rws_pkg.
`default_nettype none

module rws_front import rws_pkg::*; #(
  parameter int FITNESS_BITS = 32
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  req_valid,
  output logic       req_stall,
  input  wire req_t  req,
  output logic       q_valid,
  output item_t      q_item,
  input  wire logic  q_take
);

  localparam logic [FIT_W-1:0] FIT_MASK = (FITNESS_BITS >= FIT_W) ? '1 :
                                          FIT_W'((64'd1 << FITNESS_BITS) - 64'd1);
  localparam logic [1:0] QUEUE_DEPTH = 2'd2;

  item_t      slots [2];
  item_t      dec;
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  logic       pop;

  always_comb begin
    dec.op         = req.cmd ? OP_QUERY : OP_LOAD;
    dec.restart    = req.new_population;
    dec.fitness    = req.fitness & FIT_MASK;
    dec.pick_value = req.pick_value;
  end

  assign req_stall = (fill == QUEUE_DEPTH);
  assign push      = req_valid && !req_stall;
  assign q_valid   = (fill != 2'd0);
  assign pop       = q_valid && q_take;
  assign q_item    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      fill   <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      unique case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= dec;
  end

endmodule

`default_nettype wire

/* hw/rtl/rws_back.sv */
// rws_back: executes queued items; loads append saturating prefix sums to the table, a restart
// load starting it anew, and queries binary-search it one probe per cycle. Depends on rws_pkg.
`default_nettype none

module rws_back import rws_pkg::*; #(
  parameter int POP_SIZE = 512
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  q_valid,
  input  wire item_t q_item,
  output logic       q_take,
  output logic       rsp_valid,
  input  wire logic  rsp_stall,
  output rsp_t       rsp
);

  localparam int IW = $clog2(POP_SIZE);
  localparam int CW = $clog2(POP_SIZE + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_DONE
  } state_t;

  state_t              state;
  logic [CW-1:0]       count;
  logic [SUM_BITS-1:0] total;
  logic [IW-1:0]       lo;
  logic [IW-1:0]       hi;
  logic [SUM_BITS-1:0] pick;
  logic                empty;

  logic [SUM_BITS-1:0] mem [POP_SIZE];
  logic [SUM_BITS-1:0] rdata;

  logic                take;
  logic                is_load;
  logic                is_query;
  logic [CW-1:0]       base_count;
  logic [SUM_BITS-1:0] base_total;
  logic [SUM_BITS:0]   sum_wide;
  logic [SUM_BITS-1:0] sum_sat;
  logic                room;
  logic                wr_en;
  logic [IW-1:0]       wr_addr;
  logic [CW-1:0]       count_next;
  logic [IW-1:0]       last;
  logic [IW-1:0]       mid_cur;
  logic                hit;
  logic [IW-1:0]       lo_n;
  logic [IW-1:0]       hi_n;
  logic [IW-1:0]       raddr;
  logic                rsp_load;

  assign q_take   = (state == S_IDLE);
  assign take     = q_take && q_valid;
  assign is_load  = take && (q_item.op == OP_LOAD);
  assign is_query = take && (q_item.op == OP_QUERY);
  assign rsp_load = (state == S_DONE) && (!rsp_valid || !rsp_stall);

  always_comb begin
    base_count = q_item.restart ? '0 : count;
    base_total = q_item.restart ? '0 : total;
    sum_wide   = {1'b0, base_total} + (SUM_BITS + 1)'(q_item.fitness);
    sum_sat    = sum_wide[SUM_BITS] ? '1 : sum_wide[SUM_BITS-1:0];
    room       = (base_count != CW'(POP_SIZE));
    wr_en      = is_load && room;
    wr_addr    = base_count[IW-1:0];
    count_next = base_count + CW'(1);
    last       = IW'(count - CW'(1));
    mid_cur    = lo + ((hi - lo) >> 1);
    hit        = (rdata >= pick);
    if (state == S_IDLE) begin
      lo_n = '0;
      hi_n = last;
    end else begin
      lo_n = hit ? lo : (mid_cur + IW'(1));
      hi_n = hit ? mid_cur : hi;
    end
    raddr = lo_n + ((hi_n - lo_n) >> 1);
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= sum_sat;
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      total     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_load) rsp_valid <= 1'b1;
      else if (rsp_valid && !rsp_stall) rsp_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (wr_en) begin
            count <= count_next;
            total <= sum_sat;
          end
          if (is_query) begin
            pick  <= q_item.pick_value;
            lo    <= lo_n;
            hi    <= hi_n;
            empty <= (count == '0);
            state <= (count > CW'(1)) ? S_SEARCH : S_DONE;
          end
        end
        S_SEARCH: begin
          lo <= lo_n;
          hi <= hi_n;
          if (!(lo_n < hi_n)) state <= S_DONE;
        end
        S_DONE: begin
          if (rsp_load) begin
            rsp.selected_index <= empty ? '0 : IDX_BITS'(lo);
            rsp.total_sum      <= empty ? '0 : total;
            rsp.empty_res      <= empty;
            state              <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
